[sv/ptw_pkg.sv]
package ptw_pkg;

    // Default sizing
    localparam int PTW_POOL_TABLES = 8;
    localparam int PTW_LEVELS      = 4;

    // Fixed table geometry
    localparam int ENTRIES_PER_TABLE = 512;
    localparam int IDX_W             = 9;
    localparam int PAGE_SHIFT        = 12;
    localparam int PFN_W             = 40;
    localparam int PHYS_W            = 52;

    // Configuration port
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_ROOT_TABLE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_POOL_BASE  = 2'd1;

    // Result status codes
    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_POOL_FULL = 2'd1;
    localparam logic [1:0] STATUS_OUTSIDE   = 2'd2;

    // Walk sequencer states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RESOLVE,
        ST_READ,
        ST_ALLOC,
        ST_DONE
    } walk_state_t;

endpackage

[sv/page_table_map_walker.sv]
// A walk runs from an accepted start to the done strobe through resolve, read and, where a
// table is missing, allocate steps at each level; an error ends the walk sooner.
// One request at a time: busy stays high through the walk and drops the cycle after done,
// and one table-store port and one 40-bit adder serve every step of the walk.
// Reset: asynchronous, active low; the table store is then swept to zero with busy high.
// Results come as a one-cycle done strobe.
module page_table_map_walker #(
    parameter int POOL_TABLES = ptw_pkg::PTW_POOL_TABLES,
    parameter int LEVELS      = ptw_pkg::PTW_LEVELS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // Request beat
    input  logic                          start,
    output logic                          busy,
    input  logic [47:0]                   virtual_address,
    input  logic [51:0]                   physical_address,
    input  logic [63:0]                   leaf_flags,
    // Result beat
    output logic                          done,
    output logic [1:0]                    status,
    output logic [63:0]                   leaf_entry,
    output logic [1:0]                    new_tables,
    output logic [3:0]                    tables_in_use,
    // Configuration write channel
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [ptw_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [51:0]                   cfg_data
);
    import ptw_pkg::*;

    localparam int NSLOTS = POOL_TABLES + 1;
    localparam int SW     = $clog2(NSLOTS);
    localparam int DEPTH  = NSLOTS * ENTRIES_PER_TABLE;
    localparam int AW     = SW + IDX_W;
    localparam int LW     = $clog2(LEVELS);
    localparam int VAW    = (PAGE_SHIFT + IDX_W * LEVELS > 48) ?
                            PAGE_SHIFT + IDX_W * LEVELS : 48;

    // Control state
    walk_state_t       state_reg, state_next;
    logic [AW-1:0]     clr_reg, clr_next;
    logic [LW-1:0]     lvl_reg, lvl_next;
    logic [SW-1:0]     pool_count_reg, pool_count_next;
    logic              epoch_reg [NSLOTS];
    logic [PFN_W-1:0]  root_pfn_reg, pool_pfn_reg;

    // Request payload and walk datapath
    logic [47:0]       va_reg;
    logic [PFN_W-1:0]  pa_pfn_reg;
    logic [63:0]       flags_reg;
    logic [PFN_W-1:0]  ptr_reg, ptr_next;
    logic [SW-1:0]     slot_reg, slot_next;
    logic [1:0]        status_reg, status_next;
    logic [63:0]       leaf_reg, leaf_next;
    logic [1:0]        fresh_reg, fresh_next;

    // Table store: entry plus one epoch tag bit
    logic [64:0]       mem [DEPTH];
    logic [64:0]       rd_reg;
    logic              mem_we;
    logic [AW-1:0]     mem_addr;
    logic [64:0]       mem_wdata;

    // Shared adder and resolve logic
    logic [PFN_W-1:0]  add_a, add_b, add_sum;
    logic              add_cin;
    logic              root_hit, in_pool, slot_ok;
    logic [SW-1:0]     slot_calc;
    logic [IDX_W-1:0]  idx;
    logic [VAW-1:0]    va_ext;
    logic              last_lvl, pool_full, tag_calc;
    logic [63:0]       entry_rd, leaf_val, table_entry;
    logic [SW-1:0]     new_slot;

    assign cfg_ready = 1'b1;

    // Slice the virtual address for the current level
    assign va_ext = VAW'(va_reg);
    always_comb
    begin
        idx = '0;
        for (int l = 0; l < LEVELS; l++)
        begin
            if (lvl_reg == LW'(l))
                idx = va_ext[PAGE_SHIFT + IDX_W * (LEVELS - 1 - l) +: IDX_W];
        end
    end

    // One adder: pointer minus pool base while resolving, base plus count while allocating
    always_comb
    begin
        if (state_reg == ST_ALLOC)
        begin
            add_a   = pool_pfn_reg;
            add_b   = PFN_W'(pool_count_reg);
            add_cin = 1'b0;
        end
        else
        begin
            add_a   = ptr_reg;
            add_b   = ~pool_pfn_reg;
            add_cin = 1'b1;
        end
    end
    assign add_sum = add_a + add_b + PFN_W'(add_cin);

    // Map a table pointer to a store slot; the root wins over an overlapping pool table
    assign root_hit  = (ptr_reg == root_pfn_reg);
    assign in_pool   = (add_sum < PFN_W'(POOL_TABLES));
    assign slot_ok   = root_hit || in_pool;
    assign slot_calc = root_hit ? '0 : add_sum[SW-1:0] + SW'(1);

    assign last_lvl  = (lvl_reg == LW'(LEVELS - 1));
    assign pool_full = (pool_count_reg == SW'(POOL_TABLES));
    assign new_slot  = pool_count_reg + SW'(1);

    // An entry tagged with a stale epoch belongs to a table cleared since; read it as zero
    assign entry_rd    = (rd_reg[64] == epoch_reg[slot_reg]) ? rd_reg[63:0] : 64'd0;
    assign leaf_val    = {12'd0, pa_pfn_reg, 12'd0} | flags_reg | 64'd1;
    assign table_entry = {12'd0, add_sum, 12'd3};
    // A table that points into itself is cleared before the entry lands
    assign tag_calc    = (slot_reg == new_slot) ? 1'b1 : epoch_reg[slot_reg];

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
                if (clr_reg == AW'(DEPTH - 1))
                    state_next = ST_IDLE;
            ST_IDLE:
                if (start)
                    state_next = ST_RESOLVE;
            ST_RESOLVE:
                if (!slot_ok || last_lvl)
                    state_next = ST_DONE;
                else
                    state_next = ST_READ;
            ST_READ:
                if (entry_rd[0])
                    state_next = ST_RESOLVE;
                else if (pool_full)
                    state_next = ST_DONE;
                else
                    state_next = ST_ALLOC;
            ST_ALLOC:
                state_next = ST_RESOLVE;
            ST_DONE:
                state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Outputs and datapath updates
    always_comb
    begin
        busy            = (state_reg != ST_IDLE);
        done            = (state_reg == ST_DONE);
        clr_next        = clr_reg;
        lvl_next        = lvl_reg;
        pool_count_next = pool_count_reg;
        ptr_next        = ptr_reg;
        slot_next       = slot_reg;
        status_next     = status_reg;
        leaf_next       = leaf_reg;
        fresh_next      = fresh_reg;
        mem_we          = 1'b0;
        mem_addr        = {slot_reg, idx};
        mem_wdata       = {tag_calc, table_entry};
        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_addr  = clr_reg;
                mem_wdata = '0;
                clr_next  = clr_reg + AW'(1);
            end
            ST_IDLE:
            begin
                lvl_next    = '0;
                ptr_next    = root_pfn_reg;
                status_next = STATUS_OK;
                leaf_next   = '0;
                fresh_next  = '0;
            end
            ST_RESOLVE:
            begin
                mem_addr  = {slot_calc, idx};
                slot_next = slot_calc;
                if (!slot_ok)
                begin
                    status_next = STATUS_OUTSIDE;
                    leaf_next   = '0;
                end
                else if (last_lvl)
                begin
                    mem_we    = 1'b1;
                    mem_wdata = {epoch_reg[slot_calc], leaf_val};
                    leaf_next = leaf_val;
                end
            end
            ST_READ:
            begin
                if (entry_rd[0])
                begin
                    ptr_next = entry_rd[PAGE_SHIFT +: PFN_W];
                    lvl_next = lvl_reg + LW'(1);
                end
                else if (pool_full)
                begin
                    status_next = STATUS_POOL_FULL;
                    leaf_next   = '0;
                end
            end
            ST_ALLOC:
            begin
                mem_we          = 1'b1;
                ptr_next        = add_sum;
                lvl_next        = lvl_reg + LW'(1);
                pool_count_next = new_slot;
                fresh_next      = fresh_reg + 2'd1;
            end
            ST_DONE:
            begin
            end
            default:
            begin
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            clr_reg        <= '0;
            lvl_reg        <= '0;
            pool_count_reg <= '0;
            root_pfn_reg   <= '0;
            pool_pfn_reg   <= '0;
            for (int s = 0; s < NSLOTS; s++)
                epoch_reg[s] <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_reg        <= clr_next;
            lvl_reg        <= lvl_next;
            pool_count_reg <= pool_count_next;
            // Advance the epoch of a freshly allocated table
            if (state_reg == ST_ALLOC)
                epoch_reg[new_slot] <= 1'b1;
            // Take configuration beats
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_ROOT_TABLE)
                    root_pfn_reg <= cfg_data[PAGE_SHIFT +: PFN_W];
                else if (cfg_index == CFG_POOL_BASE)
                    pool_pfn_reg <= cfg_data[PAGE_SHIFT +: PFN_W];
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && start)
        begin
            va_reg     <= virtual_address;
            pa_pfn_reg <= physical_address[PAGE_SHIFT +: PFN_W];
            flags_reg  <= leaf_flags;
        end
        ptr_reg    <= ptr_next;
        slot_reg   <= slot_next;
        status_reg <= status_next;
        leaf_reg   <= leaf_next;
        fresh_reg  <= fresh_next;
    end

    // Table store port
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_addr] <= mem_wdata;
        rd_reg <= mem[mem_addr];
    end

    assign status        = status_reg;
    assign leaf_entry    = leaf_reg;
    assign new_tables    = fresh_reg;
    assign tables_in_use = 4'(pool_count_reg);

    // Checks
    a_pool_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pool_count_reg <= SW'(POOL_TABLES))
        else $error("pool count beyond pool size");

    a_alloc_count: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_ALLOC |=> pool_count_reg == $past(pool_count_reg) + SW'(1))
        else $error("allocation did not advance pool count");

    a_err_leaf: assert property (@(posedge clk) disable iff (!rst_n)
        done && status != STATUS_OK |-> leaf_entry == 64'd0)
        else $error("leaf entry not zero on error");

    a_start_walk: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> state_reg == ST_RESOLVE && lvl_reg == '0)
        else $error("accepted request did not start a walk");

    a_alloc_only_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_ALLOC |-> !pool_full && lvl_reg != LW'(LEVELS - 1))
        else $error("allocation with full pool or at leaf level");

endmodule
